// ===== src/pvb_pkg.sv =====
// Package for the three-chamber bang-bang pressure valve controller.
// Holds request and result types, register indexes and reset values.
// No dependencies; compile first.
package pvb_pkg;

  // Field widths
  localparam int unsigned PressW = 16;
  localparam int unsigned BandW  = 15;
  localparam int unsigned PosW   = 3;
  localparam int unsigned NumPos = 1 << PosW;
  localparam int unsigned ValveW = 2 * NumPos;
  localparam int unsigned CfgIdxW = 3;

  // Register reset values
  localparam logic [BandW-1:0] DeadbandRst = 15'd10;
  localparam logic [BandW-1:0] MarginRst   = 15'd130;
  localparam logic [PosW-1:0]  PosARst     = 3'd0;
  localparam logic [PosW-1:0]  PosBRst     = 3'd3;
  localparam logic [PosW-1:0]  PosCRst     = 3'd6;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEADBAND = 3'd0,
    REG_MARGIN   = 3'd1,
    REG_POS_A    = 3'd2,
    REG_POS_B    = 3'd3,
    REG_POS_C    = 3'd4
  } cfg_reg_e;

  // One input request
  typedef struct packed {
    logic signed [PressW-1:0] measured_a;
    logic signed [PressW-1:0] measured_b;
    logic signed [PressW-1:0] measured_c;
    logic signed [PressW-1:0] target_a;
    logic signed [PressW-1:0] target_b;
    logic signed [PressW-1:0] target_c;
    logic                     first_step;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [ValveW-1:0] valve_word;
    logic              settled_a;
    logic              settled_b;
    logic              settled_c;
    logic              all_settled;
  } out_item_t;

  // Configuration write
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [BandW-1:0]   data;
  } cfg_wr_t;

  // Controller state: valve word and per-position settled flags
  typedef struct packed {
    logic [ValveW-1:0] valves;
    logic [NumPos-1:0] settled;
  } ctl_state_t;

endpackage

// ===== src/pvb_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload type is supplied at instantiation.
interface pvb_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pressure_valve_bang_bang.sv =====
// Top level of the three-chamber bang-bang pressure valve controller.
// Uses pvb_pkg for types and constants and pvb_if for the channels.
//
//  channel  dir  payload      notes
//  -------  ---  -----------  ------------------------------------------
//  cfg_i    in   cfg_wr_t     register write, always ready
//  in_i     in   in_item_t    pressures for chambers a, b, c + first_step
//  out_o    out  out_item_t   valve word and settled flags, one per request
//
// One request per cycle while results are taken. A request passes the input
// register, then the result register; the chamber decisions and the state
// update sit in the single combinational step between the two registers.
// Reset loads register defaults, clears valves and settled flags, empties
// both stages. A stalled result keeps the input register full; input ready
// drops only when both stages hold data and the result is not taken.
module pressure_valve_bang_bang
  import pvb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pvb_if.sink   cfg_i,
  pvb_if.sink   in_i,
  pvb_if.source out_o
);

  // Configuration registers
  logic [BandW-1:0] deadband_q;
  logic [BandW-1:0] margin_q;
  logic [PosW-1:0]  pos_a_q, pos_b_q, pos_c_q;

  // Pipeline registers
  logic       in_vld_q;
  in_item_t   in_q;
  logic       out_vld_q;
  out_item_t  out_q;
  out_item_t  out_d;

  // Controller state
  ctl_state_t state_q, state_d;

  logic out_adv, in_adv;
  logic [PressW-1:0] thr;

  // One chamber's decision applied to the running state
  function automatic ctl_state_t drive_chamber(
    input ctl_state_t               st,
    input logic [PosW-1:0]          pos,
    input logic signed [PressW-1:0] meas,
    input logic signed [PressW-1:0] targ,
    input logic [PressW-1:0]        thr_v,
    input logic [BandW-1:0]         db
  );
    logic signed [PressW+1:0] err;
    logic signed [PressW+1:0] thr_s;
    logic signed [PressW+1:0] db_s;
    logic [NumPos-1:0]        inf;
    logic [ValveW-1:0]        inf_w, exh_w;
    ctl_state_t               nx;
    err   = (PressW+2)'(meas) - (PressW+2)'(targ);
    thr_s = $signed({2'b00, thr_v});
    db_s  = $signed({3'b000, db});
    inf   = NumPos'(1) << pos;
    inf_w = {{NumPos{1'b0}}, inf};
    exh_w = {inf, {NumPos{1'b0}}};
    nx    = st;
    if (err > thr_s) begin
      nx.valves  = (st.valves | exh_w) & ~inf_w;
      nx.settled = st.settled & ~inf;
    end else if (err < -thr_s) begin
      nx.valves  = (st.valves | inf_w) & ~exh_w;
      nx.settled = st.settled & ~inf;
    end else if ((err < db_s) && (err > -db_s)) begin
      nx.valves  = st.valves & ~(inf_w | exh_w);
      nx.settled = st.settled | inf;
    end
    return nx;
  endfunction

  // Handshake: result stage frees when taken, input stage when it moves on
  assign out_adv     = !out_vld_q || out_o.ready;
  assign in_adv      = in_vld_q && out_adv;
  assign in_i.ready  = !in_vld_q || out_adv;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Action threshold
  assign thr = in_q.first_step ? {1'b0, deadband_q}
                               : PressW'({1'b0, deadband_q}) + PressW'({1'b0, margin_q});

  // Chambers a, b, c in order; a later chamber that acts wins on a shared position
  always_comb begin
    ctl_state_t s1, s2, s3;
    s1 = drive_chamber(state_q, pos_a_q, in_q.measured_a, in_q.target_a, thr, deadband_q);
    s2 = drive_chamber(s1, pos_b_q, in_q.measured_b, in_q.target_b, thr, deadband_q);
    s3 = drive_chamber(s2, pos_c_q, in_q.measured_c, in_q.target_c, thr, deadband_q);
    state_d               = s3;
    out_d.valve_word      = s3.valves;
    out_d.settled_a       = s3.settled[pos_a_q];
    out_d.settled_b       = s3.settled[pos_b_q];
    out_d.settled_c       = s3.settled[pos_c_q];
    out_d.all_settled     = s3.settled[pos_a_q] & s3.settled[pos_b_q]
                            & s3.settled[pos_c_q];
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DeadbandRst;
      margin_q   <= MarginRst;
      pos_a_q    <= PosARst;
      pos_b_q    <= PosBRst;
      pos_c_q    <= PosCRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.data.index))
        REG_DEADBAND: deadband_q <= cfg_i.data.data;
        REG_MARGIN:   margin_q   <= cfg_i.data.data;
        REG_POS_A:    pos_a_q    <= cfg_i.data.data[PosW-1:0];
        REG_POS_B:    pos_b_q    <= cfg_i.data.data[PosW-1:0];
        REG_POS_C:    pos_c_q    <= cfg_i.data.data[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
      if (in_adv) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (in_adv) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // Inflate and exhaust of one position are never open together
  a_no_dual_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.valves[NumPos-1:0] & state_q.valves[ValveW-1:NumPos]) == '0)
    else $error("inflate and exhaust open at the same position");

  // A settled position has both valves closed
  a_settled_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.settled & (state_q.valves[NumPos-1:0] | state_q.valves[ValveW-1:NumPos])) == '0)
    else $error("settled position with an open valve");

  // State changes only when a request moves into the result stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_adv |=> $stable(state_q))
    else $error("state changed without a request");

  // Result valve word matches the state it produced
  a_out_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> (out_q.valve_word == state_q.valves))
    else $error("result valve word differs from state");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench for pressure_valve_bang_bang: random and directed pressure requests
// against an in-bench valve and settle-flag model. Depends on pvb_pkg, pvb_if
// and the controller RTL; needs nothing else.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pvb_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int SqueezeCycles = 300;
  localparam int NumPhases     = 11;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  pvb_if #(.payload_t(cfg_wr_t))   cfg_ch ();
  pvb_if #(.payload_t(in_item_t))  req_ch ();
  pvb_if #(.payload_t(out_item_t)) res_ch ();

  pressure_valve_bang_bang dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  // Model copy of the registers and the controller state
  logic [BandW-1:0]  m_deadband = DeadbandRst;
  logic [BandW-1:0]  m_margin   = MarginRst;
  logic [PosW-1:0]   m_pos_a    = PosARst;
  logic [PosW-1:0]   m_pos_b    = PosBRst;
  logic [PosW-1:0]   m_pos_c    = PosCRst;
  logic [ValveW-1:0] m_valves   = '0;
  logic [NumPos-1:0] m_settled  = '0;

  in_item_t  pending_readings[$];
  out_item_t predicted_results[$];

  int errors       = 0;
  bit idle_mode    = 1'b0;
  bit squeeze_req  = 1'b0;
  bit squeeze_seen = 1'b0;
  int squeeze_left = 0;
  int send_gap     = 0;
  int recv_gap     = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand_span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // One chamber decision; later chambers at the same position overwrite
  function automatic void update_chamber(input logic [PosW-1:0] pos, input int err,
                                         input int thr);
    int db, ip, ep;
    db = int'(m_deadband);
    ip = int'(pos);
    ep = ip + NumPos;
    if (err > thr) begin
      m_valves[ep] = 1'b1;
      m_valves[ip] = 1'b0;
      m_settled[ip] = 1'b0;
    end else if (-err > thr) begin
      m_valves[ip] = 1'b1;
      m_valves[ep] = 1'b0;
      m_settled[ip] = 1'b0;
    end else if (err < db && -err < db) begin
      m_valves[ip] = 1'b0;
      m_valves[ep] = 1'b0;
      m_settled[ip] = 1'b1;
    end
  endfunction

  // Advance the valve model by one request and queue the expected result
  function automatic void predict_valves(input in_item_t r);
    int thr;
    out_item_t o;
    thr = int'(m_deadband) + (r.first_step ? 0 : int'(m_margin));
    update_chamber(m_pos_a, int'($signed(r.measured_a)) - int'($signed(r.target_a)), thr);
    update_chamber(m_pos_b, int'($signed(r.measured_b)) - int'($signed(r.target_b)), thr);
    update_chamber(m_pos_c, int'($signed(r.measured_c)) - int'($signed(r.target_c)), thr);
    o.valve_word  = m_valves;
    o.settled_a   = m_settled[m_pos_a];
    o.settled_b   = m_settled[m_pos_b];
    o.settled_c   = m_settled[m_pos_c];
    o.all_settled = o.settled_a & o.settled_b & o.settled_c;
    predicted_results.push_back(o);
  endfunction

  function automatic void add_reading(input int ma, input int ta, input int mb,
                                      input int tb, input int mc, input int tc,
                                      input bit first);
    in_item_t r;
    r.measured_a = 16'(ma);
    r.target_a   = 16'(ta);
    r.measured_b = 16'(mb);
    r.target_b   = 16'(tb);
    r.measured_c = 16'(mc);
    r.target_c   = 16'(tc);
    r.first_step = first;
    pending_readings.push_back(r);
  endfunction

  // Pressure pair whose error mostly lands on or next to a band edge
  function automatic void pick_pressures(input int thr, input int db,
                                         output logic [15:0] meas,
                                         output logic [15:0] targ);
    int err, lo, hi, t;
    case ($urandom_range(0, 13)) inside
      0:       err = db - 1;
      1:       err = db;
      2:       err = db + 1;
      3:       err = 1 - db;
      4:       err = -db;
      5:       err = -db - 1;
      6:       err = thr;
      7:       err = thr + 1;
      8:       err = -thr;
      9:       err = -thr - 1;
      10:      err = 0;
      11, 12:  err = rand_span(-2 * thr - 8, 2 * thr + 8);
      default: begin
        // noise: any pair at all
        meas = 16'($urandom);
        targ = 16'($urandom);
        return;
      end
    endcase
    if (err > 65535) err = 65535;
    if (err < -65535) err = -65535;
    lo = (err < 0) ? -32768 - err : -32768;
    hi = (err > 0) ? 32767 - err : 32767;
    t = rand_span(lo, hi);
    targ = 16'(t);
    meas = 16'(t + err);
  endfunction

  function automatic in_item_t random_reading();
    in_item_t r;
    int thr;
    r.first_step = ($urandom_range(0, 2) == 0);
    thr = int'(m_deadband) + (r.first_step ? 0 : int'(m_margin));
    pick_pressures(thr, int'(m_deadband), r.measured_a, r.target_a);
    pick_pressures(thr, int'(m_deadband), r.measured_b, r.target_b);
    pick_pressures(thr, int'(m_deadband), r.measured_c, r.target_c);
    return r;
  endfunction

  function automatic logic [BandW-1:0] pick_band();
    case ($urandom_range(0, 9)) inside
      0:       return '0;
      1:       return '1;
      2, 3:    return BandW'($urandom_range(0, 32767));
      default: return BandW'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (predicted_results.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      errors++;
      return;
    end
    want = predicted_results.pop_front();
    compare_field("valve_word", want.valve_word, got.valve_word);
    compare_field("settled_a", 16'(want.settled_a), 16'(got.settled_a));
    compare_field("settled_b", 16'(want.settled_b), 16'(got.settled_b));
    compare_field("settled_c", 16'(want.settled_c), 16'(got.settled_c));
    compare_field("all_settled", 16'(want.all_settled), 16'(got.all_settled));
  endtask

  // Register write; called at a rising edge, returns at the accepting edge
  task automatic write_reg(input cfg_reg_e idx, input logic [BandW-1:0] val);
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= val;
    cfg_ch.valid      <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_DEADBAND: m_deadband = val;
      REG_MARGIN:   m_margin   = val;
      REG_POS_A:    m_pos_a    = val[PosW-1:0];
      REG_POS_B:    m_pos_b    = val[PosW-1:0];
      REG_POS_C:    m_pos_c    = val[PosW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [BandW-1:0] db, input logic [BandW-1:0] margin,
                              input int pa, input int pb, input int pc);
    @(posedge clk_i);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_MARGIN, margin);
    write_reg(REG_POS_A, BandW'(pa));
    write_reg(REG_POS_B, BandW'(pb));
    write_reg(REG_POS_C, BandW'(pc));
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every request is sent and every result is back, plus latency
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_readings.size() != 0 || req_ch.valid || predicted_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      send_gap     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_valves(req_ch.data);
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          req_ch.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (pending_readings.size() > 0) begin
          req_ch.data  <= pending_readings.pop_front();
          req_ch.valid <= 1'b1;
          send_gap     <= idle_mode ? pick_gap() : 0;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long result hold-off, started by a toggle of squeeze_req
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      squeeze_seen <= 1'b0;
      squeeze_left <= 0;
    end else if (squeeze_req != squeeze_seen) begin
      squeeze_seen <= squeeze_req;
      squeeze_left <= SqueezeCycles;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
    end
  end

  // Result monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_result(res_ch.data);
      if (recv_gap > 0) begin
        res_ch.ready <= 1'b0;
        recv_gap     <= recv_gap - 1;
      end else if (squeeze_left > 0) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (idle_mode && $urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("pressure_valve_bang_bang: mismatch");
    $finish;
  end

  // Phases: register setting, directed requests, random requests, drain
  initial begin : stimulus
    int phase;
    int n;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase == 1) begin
        // zero band, all chambers on one position
        program_regs('0, '0, 1, 1, 1);
      end else if (phase == 2) begin
        program_regs('1, '1, 7, 0, 7);
      end else if (phase >= 3) begin
        program_regs(pick_band(), pick_band(), $urandom_range(0, 7),
                     $urandom_range(0, 7), $urandom_range(0, 7));
      end
      case (phase) inside
        0, 3, 5: idle_mode <= 1'b0;
        1, 2, 4: idle_mode <= 1'b1;
        default: idle_mode <= ($urandom_range(0, 3) != 0);
      endcase
      @(negedge clk_i);

      case (phase)
        0: begin
          // reset settings: band 10, action 10 on first step, 140 after
          add_reading(0, 0, 0, 0, 0, 0, 1'b1);
          add_reading(11, 0, -11, 0, 10, 0, 1'b1);
          add_reading(-10, 0, 9, 0, -9, 0, 1'b1);
          add_reading(140, 0, -140, 0, 141, 0, 1'b0);
          add_reading(0, 141, 0, 0, 0, 0, 1'b0);
          add_reading(0, -141, 32767, -32768, -32768, 32767, 1'b0);
          add_reading(-32768, -32768, 32767, 32767, 5, -4, 1'b1);
          add_reading(100, -41, 0, 0, 0, 0, 1'b0);
          add_reading(-32768, 32767, 32767, -32768, 0, 0, 1'b1);
          add_reading(1, 0, -1, 0, 0, 0, 1'b1);
        end
        1: begin
          // chamber c wins the shared position; zero band never settles
          add_reading(1, 0, 0, 0, -1, 0, 1'b1);
          add_reading(0, 0, 0, 0, 0, 0, 1'b1);
          add_reading(0, 0, 0, 0, 0, 0, 1'b0);
          add_reading(5, 0, -3, 0, 0, 0, 1'b0);
        end
        2: begin
          // widest threshold: only the full-scale error acts
          add_reading(32767, -32768, 0, 0, -32768, 32767, 1'b0);
          add_reading(32767, -32767, 0, 0, -32767, 32767, 1'b0);
          add_reading(0, 0, 32767, 0, 0, 0, 1'b1);
        end
        default: ;
      endcase

      n = (phase == 0) ? 0 : ((phase < 3) ? 55 : 65);
      repeat (n) pending_readings.push_back(random_reading());
      if (phase == 5) squeeze_req <= ~squeeze_req;
      wait_drained();
    end

    if (errors == 0)
      $display("pressure_valve_bang_bang: match");
    else
      $display("pressure_valve_bang_bang: mismatch");
    $finish;
  end

endmodule
